// ----- rtl/v2cd_pkg.sv -----
// Package for the vector-to-compass-degrees block: widths, payload types,
// status struct and the stepped angle correction. No dependencies.
package v2cd_pkg;

   localparam int INPUT_BITS = 16;
   localparam int MAG_W      = INPUT_BITS - 1;
   localparam int QUOT_W     = 6;
   localparam int NUM_W      = MAG_W + QUOT_W;
   localparam int ANGLE_W    = 9;
   localparam int CORR_W     = 3;

   localparam logic [ANGLE_W-1:0] DEG_90  = ANGLE_W'(90);
   localparam logic [ANGLE_W-1:0] DEG_180 = ANGLE_W'(180);
   localparam logic [ANGLE_W-1:0] DEG_360 = ANGLE_W'(360);

   typedef struct packed {
      logic signed [INPUT_BITS-1:0] x_component;
      logic signed [INPUT_BITS-1:0] y_component;
   } req_type;

   typedef struct packed {
      logic [ANGLE_W-1:0] angle_degrees;
      logic               zero_vector;
   } rsp_type;

   // Per-item side information carried beside the datapath.
   typedef struct packed {
      logic xneg;
      logic yneg;
      logic mirror;
      logic zero;
   } flags_type;

   // Stepped correction of 0..4 degrees on the raw quotient.
   function automatic logic [CORR_W-1:0] correction(input logic [QUOT_W-1:0] d);
      logic [CORR_W-1:0] c;
      c = '0;
      if (d > QUOT_W'(22)) begin
         if (d <= QUOT_W'(44)) c = c + CORR_W'(1);
         if (d <= QUOT_W'(41)) c = c + CORR_W'(1);
         if (d <= QUOT_W'(37)) c = c + CORR_W'(1);
         if (d <= QUOT_W'(32)) c = c + CORR_W'(1);
      end else begin
         if (d >= QUOT_W'(2))  c = c + CORR_W'(1);
         if (d >= QUOT_W'(6))  c = c + CORR_W'(1);
         if (d >= QUOT_W'(10)) c = c + CORR_W'(1);
         if (d >= QUOT_W'(15)) c = c + CORR_W'(1);
      end
      return c;
   endfunction

endpackage

// ----- rtl/v2cd_front.sv -----
// Front end: magnitudes, octant select and smaller magnitude times 45.
// Two register stages. Depends on v2cd_pkg.
module v2cd_front (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        in_valid,
   input  v2cd_pkg::req_type           in_req,
   output logic                        out_valid,
   output logic [v2cd_pkg::NUM_W-1:0]  out_num,
   output logic [v2cd_pkg::MAG_W-1:0]  out_large,
   output v2cd_pkg::flags_type         out_flags
);

   localparam int IB = v2cd_pkg::INPUT_BITS;
   localparam int MW = v2cd_pkg::MAG_W;
   localparam int NW = v2cd_pkg::NUM_W;

   function automatic logic [MW-1:0] mag(input logic [IB-1:0] v);
      logic [IB-1:0] n;
      n = -v;
      if (!v[IB-1]) return v[MW-1:0];
      if (v == {1'b1, {(IB-1){1'b0}}}) return {MW{1'b1}};  // clamp most negative
      return n[MW-1:0];
   endfunction

   logic [MW-1:0]       ux, uy;
   logic                v1_ff, v2_ff;
   logic [MW-1:0]       small_ff, small_in, large_ff, large_in, large2_ff;
   v2cd_pkg::flags_type flags_ff, flags_in, flags2_ff;
   logic [NW-1:0]       num_ff, num_in;

   always_comb begin
      ux = mag(in_req.x_component);
      uy = mag(in_req.y_component);
      flags_in.xneg   = in_req.x_component[IB-1];
      flags_in.yneg   = in_req.y_component[IB-1];
      flags_in.mirror = (ux > uy);
      flags_in.zero   = (ux == '0) && (uy == '0);
      small_in = flags_in.mirror ? uy : ux;
      large_in = flags_in.mirror ? ux : uy;
   end

   // x*45 = x*32 + x*8 + x*4 + x
   assign num_in = (NW'(small_ff) << 5) + (NW'(small_ff) << 3)
                 + (NW'(small_ff) << 2) + NW'(small_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
      end
      small_ff  <= small_in;
      large_ff  <= large_in;
      flags_ff  <= flags_in;
      num_ff    <= num_in;
      large2_ff <= large_ff;
      flags2_ff <= flags_ff;
   end

   assign out_valid = v2_ff;
   assign out_num   = num_ff;
   assign out_large = large2_ff;
   assign out_flags = flags2_ff;

endmodule

// ----- rtl/v2cd_divider.sv -----
// Pipelined restoring divider: one quotient bit per register stage.
// Depends on v2cd_pkg.
module v2cd_divider (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        in_valid,
   input  logic [v2cd_pkg::NUM_W-1:0]  in_num,
   input  logic [v2cd_pkg::MAG_W-1:0]  in_large,
   input  v2cd_pkg::flags_type         in_flags,
   output logic                        out_valid,
   output logic [v2cd_pkg::QUOT_W-1:0] out_quot,
   output v2cd_pkg::flags_type         out_flags
);

   localparam int QW = v2cd_pkg::QUOT_W;
   localparam int NW = v2cd_pkg::NUM_W;
   localparam int MW = v2cd_pkg::MAG_W;

   logic                valid_ff [1:QW];
   logic [NW-1:0]       rem_ff   [1:QW];
   logic [MW-1:0]       large_ff [1:QW];
   logic [QW-1:0]       quot_ff  [1:QW];
   v2cd_pkg::flags_type flags_ff [1:QW];

   for (genvar i = 0; i < QW; i++) begin : g_step
      localparam int K = QW - 1 - i;
      logic                valid_src;
      logic [NW-1:0]       rem_src;
      logic [MW-1:0]       large_src;
      logic [QW-1:0]       quot_src;
      v2cd_pkg::flags_type flags_src;
      logic [NW-1:0]       dsh;
      logic                take;
      logic [NW-1:0]       rem_in;
      logic [QW-1:0]       quot_in;

      // first stage takes the module inputs, later ones the previous stage
      if (i == 0) begin : g_first
         assign valid_src = in_valid;
         assign rem_src   = in_num;
         assign large_src = in_large;
         assign quot_src  = '0;
         assign flags_src = in_flags;
      end else begin : g_next
         assign valid_src = valid_ff[i];
         assign rem_src   = rem_ff[i];
         assign large_src = large_ff[i];
         assign quot_src  = quot_ff[i];
         assign flags_src = flags_ff[i];
      end

      always_comb begin
         dsh     = NW'(large_src) << K;
         take    = (rem_src >= dsh);
         rem_in  = take ? rem_src - dsh : rem_src;
         quot_in = quot_src;
         quot_in[K] = take;
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[i+1] <= 1'b0;
         end else begin
            valid_ff[i+1] <= valid_src;
         end
         rem_ff[i+1]   <= rem_in;
         large_ff[i+1] <= large_src;
         quot_ff[i+1]  <= quot_in;
         flags_ff[i+1] <= flags_src;
      end
   end

   assign out_valid = valid_ff[QW];
   assign out_quot  = quot_ff[QW];
   assign out_flags = flags_ff[QW];

endmodule

// ----- rtl/v2cd_back.sv -----
// Back end: correction, mirror, quadrant fold and the result register.
// Depends on v2cd_pkg.
module v2cd_back (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        in_valid,
   input  logic [v2cd_pkg::QUOT_W-1:0] in_quot,
   input  v2cd_pkg::flags_type         in_flags,
   output logic                        out_strobe,
   output v2cd_pkg::rsp_type           out_rsp
);

   localparam int AW = v2cd_pkg::ANGLE_W;

   logic [AW-1:0]     base, oct, deg;
   logic              strobe_ff;
   v2cd_pkg::rsp_type rsp_ff, rsp_in;

   always_comb begin
      base = AW'(in_quot) + AW'(v2cd_pkg::correction(in_quot));
      oct  = in_flags.mirror ? v2cd_pkg::DEG_90 - base : base;
      if (in_flags.yneg)
         deg = in_flags.xneg ? v2cd_pkg::DEG_180 + oct : v2cd_pkg::DEG_180 - oct;
      else if (in_flags.xneg)
         deg = v2cd_pkg::DEG_360 - oct;
      else
         deg = oct;
      rsp_in.angle_degrees = in_flags.zero ? '0 : deg;
      rsp_in.zero_vector   = in_flags.zero;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         strobe_ff <= 1'b0;
      end else begin
         strobe_ff <= in_valid;
      end
      rsp_ff <= rsp_in;
   end

   assign out_strobe = strobe_ff;
   assign out_rsp    = rsp_ff;

endmodule

// ----- rtl/vector_to_compass_degrees_top.sv -----
// Vector to compass degrees, fast integer atan2. Pipeline from the start
// transfer to rsp_strobe: 2 front stages, 6 divider stages, 1 output stage.
// Throughput: one vector per cycle; the one-quotient-bit-per-stage divider
// sets the depth. busy is always low and results cannot be held off.
// Reset (synchronous, active high) clears every stage valid bit; items in
// flight are dropped and no strobe follows them.
module vector_to_compass_degrees_top (
   input  logic              clock,
   input  logic              reset,
   // request channel
   input  logic              start,
   output logic              busy,
   input  v2cd_pkg::req_type req_payload,
   // result channel, one-cycle strobe
   output logic              rsp_strobe,
   output v2cd_pkg::rsp_type rsp_payload
);

   // front -> divider
   logic                        f_valid;
   logic [v2cd_pkg::NUM_W-1:0]  f_num;
   logic [v2cd_pkg::MAG_W-1:0]  f_large;
   v2cd_pkg::flags_type         f_flags;
   // divider -> back
   logic                        d_valid;
   logic [v2cd_pkg::QUOT_W-1:0] d_quot;
   v2cd_pkg::flags_type         d_flags;

   // Fully pipelined, so every start is a transfer.
   assign busy = 1'b0;

   // Magnitudes, clamp of most negative input, smaller*45.
   v2cd_front u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (start && !busy),
      .in_req    (req_payload),
      .out_valid (f_valid),
      .out_num   (f_num),
      .out_large (f_large),
      .out_flags (f_flags)
   );

   // Quotient 0..45 of smaller*45 / larger.
   v2cd_divider u_div (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (f_valid),
      .in_num    (f_num),
      .in_large  (f_large),
      .in_flags  (f_flags),
      .out_valid (d_valid),
      .out_quot  (d_quot),
      .out_flags (d_flags)
   );

   // Correction, mirror about 45, fold into quadrant, zero-vector override.
   v2cd_back u_back (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (d_valid),
      .in_quot    (d_quot),
      .in_flags   (d_flags),
      .out_strobe (rsp_strobe),
      .out_rsp    (rsp_payload)
   );

`ifndef NO_ASSERTIONS
   a_zero_angle : assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_payload.zero_vector |-> rsp_payload.angle_degrees == '0)
      else $error("zero vector must report angle 0");

   a_angle_range : assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> rsp_payload.angle_degrees <= v2cd_pkg::DEG_360)
      else $error("angle above 360");

   a_reset_flush : assert property (@(posedge clock)
      reset |=> !rsp_strobe && !d_valid && !f_valid)
      else $error("pipeline valid bits not cleared by reset");
`endif

endmodule

// ----- tb/vector_to_compass_degrees_top_test.sv -----
`timescale 1ns / 100ps
// Testbench for vector_to_compass_degrees_top: directed and random vectors, each
// result checked against an integer atan2 predictor kept here. Needs rtl/v2cd_pkg.sv.

module vector_to_compass_degrees_top_test;

   localparam int IB           = v2cd_pkg::INPUT_BITS;
   localparam int AW           = v2cd_pkg::ANGLE_W;
   localparam int MAG_MAX      = 2**(IB-1) - 1;
   localparam int PHASE_ITEMS  = 400;
   localparam int SETTLE_TICKS = 16;   // pipeline is 9 deep, leave some margin

   // Expected-angle store plus the predictor that fills it.
   class compass_scoreboard;
      v2cd_pkg::rsp_type predicted_angles[$];
      int      vectors_sent    = 0;
      int      results_checked = 0;
      int      failures        = 0;
      int      zero_seen       = 0;
      int      wrap_seen       = 0;

      // Stepped correction added to the raw 0..45 quotient.
      function int step_correction(int q);
         int c;
         c = 0;
         if (q > 22) begin
            if (q <= 44) c++;
            if (q <= 41) c++;
            if (q <= 37) c++;
            if (q <= 32) c++;
         end else begin
            if (q >= 2)  c++;
            if (q >= 6)  c++;
            if (q >= 10) c++;
            if (q >= 15) c++;
         end
         return c;
      endfunction

      // Most negative code clamps to the largest positive magnitude.
      function int magnitude(logic signed [IB-1:0] v, output bit neg);
         int m;
         neg = v[IB-1];
         m   = neg ? -int'(v) : int'(v);
         if (m > MAG_MAX) m = MAG_MAX;
         return m;
      endfunction

      function v2cd_pkg::rsp_type compass_angle(v2cd_pkg::req_type r);
         v2cd_pkg::rsp_type a;
         int      ux, uy, deg;
         bit      xneg, yneg, mirror;
         ux = magnitude(r.x_component, xneg);
         uy = magnitude(r.y_component, yneg);
         a.zero_vector = 1'b0;
         if (ux == 0 && uy == 0) begin
            a.angle_degrees = '0;
            a.zero_vector   = 1'b1;
            return a;
         end
         if (ux > uy) begin
            deg    = (uy * 45) / ux;
            mirror = 1'b1;
         end else begin
            deg    = (ux * 45) / uy;
            mirror = 1'b0;
         end
         deg += step_correction(deg);
         if (mirror) deg = 90 - deg;
         if (yneg) deg = xneg ? 180 + deg : 180 - deg;
         else if (xneg) deg = 360 - deg;
         a.angle_degrees = AW'(deg);
         return a;
      endfunction

      function void note_vector(v2cd_pkg::req_type r);
         v2cd_pkg::rsp_type a;
         a = compass_angle(r);
         predicted_angles.push_back(a);
         vectors_sent++;
         if (a.zero_vector) zero_seen++;
         if (a.angle_degrees == v2cd_pkg::DEG_360) wrap_seen++;
      endfunction

      function void check_result(v2cd_pkg::rsp_type got);
         v2cd_pkg::rsp_type want;
         if (predicted_angles.size() == 0) begin
            failures++;
            $error("unexpected result: angle_degrees %0d zero_vector %0b",
                   got.angle_degrees, got.zero_vector);
            return;
         end
         want = predicted_angles.pop_front();
         results_checked++;
         if (got.angle_degrees !== want.angle_degrees) begin
            failures++;
            $error("angle_degrees mismatch: expected %0d, actual %0d",
                   want.angle_degrees, got.angle_degrees);
         end
         if (got.zero_vector !== want.zero_vector) begin
            failures++;
            $error("zero_vector mismatch: expected %0b, actual %0b",
                   want.zero_vector, got.zero_vector);
         end
      endfunction

      function int pending();
         return predicted_angles.size();
      endfunction
   endclass

   // ------------------------------------------------------------------
   // Block hookup. Every input has a defined value from time zero.
   // ------------------------------------------------------------------
   logic              clock;
   logic              reset       = 1'b1;
   logic              start       = 1'b0;
   v2cd_pkg::req_type req_payload = '0;
   logic              busy;
   logic              rsp_strobe;
   v2cd_pkg::rsp_type rsp_payload;

   compass_scoreboard book = new();

   vector_to_compass_degrees_top DUT (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .busy        (busy),
      .req_payload (req_payload),
      .rsp_strobe  (rsp_strobe),
      .rsp_payload (rsp_payload)
   );

   // 20 ns clock.
   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // Result side: the strobe lasts one cycle and cannot be stalled, so every
   // edge with the strobe up is a transfer. Values read here are the ones
   // from before the edge, since the block updates them nonblocking.
   always @(posedge clock) begin
      if (!reset && rsp_strobe) book.check_result(rsp_payload);
   end

   // ------------------------------------------------------------------
   // Request side. start stays high across back-to-back transfers; only an
   // explicit gap lowers it, so it never drops and rises in the same step.
   // ------------------------------------------------------------------
   task automatic send_vector(input int x, input int y);
      v2cd_pkg::req_type r;
      r.x_component = IB'(x);
      r.y_component = IB'(y);
      req_payload <= r;
      start       <= 1'b1;
      // transfer happens at the first edge that sees busy low
      do @(posedge clock); while (busy);
      book.note_vector(r);
   endtask

   task automatic idle_cycles(input int n);
      start <= 1'b0;
      repeat (n) @(posedge clock);
   endtask

   // Each cycle after a transfer the sender stays idle with chance pct.
   task automatic sender_gap(input int pct);
      while ($urandom_range(99) < pct) idle_cycles(1);
   endtask

   // Hold off until every expected angle is back, then let the pipe settle.
   task automatic drain_results();
      start <= 1'b0;
      while (book.pending() != 0) @(posedge clock);
      repeat (SETTLE_TICKS) @(posedge clock);
   endtask

   function automatic int random_sign(input int m);
      return $urandom_range(1) ? m : -m;
   endfunction

   // Mix of shapes: full-range codes (every bit toggles, -32768 included),
   // small magnitudes where the quotient steps coarsely, near-diagonals
   // around the 45 degree point, on-axis vectors and pure extremes.
   task automatic random_vector(output int x, output int y);
      int m, pick;
      int corners[6] = '{-MAG_MAX - 1, -MAG_MAX, -1, 0, 1, MAG_MAX};
      pick = $urandom_range(9);
      case (pick)
         0, 1, 2, 3, 4: begin
            x = int'($urandom_range(65535)) - 32768;
            y = int'($urandom_range(65535)) - 32768;
         end
         5, 6: begin
            x = int'($urandom_range(128)) - 64;
            y = int'($urandom_range(128)) - 64;
         end
         7: begin
            m = $urandom_range(1, MAG_MAX);
            x = random_sign(m);
            y = random_sign(m - int'($urandom_range(0, m / 16)));
            if ($urandom_range(1)) begin
               m = x; x = y; y = m;
            end
         end
         8: begin
            m = int'($urandom_range(65535)) - 32768;
            if ($urandom_range(1)) begin
               x = m; y = 0;
            end else begin
               x = 0; y = m;
            end
         end
         default: begin
            x = corners[$urandom_range(5)];
            y = corners[$urandom_range(5)];
         end
      endcase
   endtask

   // ------------------------------------------------------------------
   // Directed vectors: origin, the four axes, diagonals with clamped codes,
   // tiny negative X next to +Y (reads back as 360), and quotients sitting on
   // each correction step but 10 (Y = 45 makes the quotient equal X).
   // ------------------------------------------------------------------
   int dir_x[25] = '{0, 0, 1, 0, -1, 32767, -32768, -32768, 0, 32767, -32767, -1, 1,
                     32767, -32768, 2, 6, 15, 22, 23, 32, 37, 41, 44, 45};
   int dir_y[25] = '{0, 1, 0, -1, 0, 32767, -32768, 0, -32768, -32767, 32767, 32767,
                     -32767, 1, 32767, 45, 45, 45, 45, 45, 45, 45, 45, 45, 23};

   // Sender idle percentage per phase: none, heavy, none, light.
   int idle_pct[4] = '{0, 70, 0, 22};

   initial begin
      int x, y;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      foreach (dir_x[i]) send_vector(dir_x[i], dir_y[i]);
      drain_results();

      // Each phase ends with a full drain, so the sender also pauses until
      // nothing is outstanding.
      foreach (idle_pct[p]) begin
         repeat (PHASE_ITEMS) begin
            random_vector(x, y);
            send_vector(x, y);
            sender_gap(idle_pct[p]);
         end
         drain_results();
      end

      $display("Covered %0d vectors (%0d zero, %0d wrapping to 360) over four pacing phases;",
               book.vectors_sent, book.zero_seen, book.wrap_seen);
      $display("%0d angles compared, %0d field mismatches.",
               book.results_checked, book.failures);
      if (book.failures == 0 && book.pending() == 0) begin
         $display("PASS vector_to_compass_degrees_top");
      end else begin
         $display("FAIL vector_to_compass_degrees_top");
      end
      $finish;
   end

   // Watchdog, far beyond the slowest legal run.
   initial begin
      #5_000_000;
      $error("timeout with %0d angles outstanding", book.pending());
      $display("FAIL vector_to_compass_degrees_top");
      $finish;
   end

endmodule
